FILE: rtl/ksht_pkg.sv
package ksht_pkg;

    localparam int DEF_TABLE_SLOTS = 1024;
    localparam int KEY_W           = 64;
    localparam int COUNT_W         = 11;
    localparam int PAYLOAD_W       = 352;

    localparam logic [63:0] HASH_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_MUL2 = 64'h94d049bb133111eb;
    localparam int HASH_SH0 = 30;
    localparam int HASH_SH1 = 27;
    localparam int HASH_SH2 = 31;
    localparam int LOAD_NUM = 10;
    localparam int LOAD_DEN = 7;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MISSING    = 2'd1,
        ST_BAD_BOUNDS = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_RD,
        S_CHK,
        S_DECIDE,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_MIX,
        H_REM
    } hash_state_t;

    // True when a > b as IEEE singles; any NaN compares false.
    function automatic logic single_greater(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan;
        logic        b_nan;
        logic [31:0] a_ord;
        logic [31:0] b_ord;
        a_nan = (a[30:0] > 31'h7f800000);
        b_nan = (b[30:0] > 31'h7f800000);
        a_ord = a[31] ? ~a : {1'b1, a[30:0]};
        b_ord = b[31] ? ~b : {1'b1, b[30:0]};
        if (a_nan || b_nan || ((a[30:0] | b[30:0]) == 31'd0))
            return 1'b0;
        return a_ord > b_ord;
    endfunction

    function automatic logic bounds_bad(input logic [63:0] packed_b);
        return single_greater(packed_b[31:0], packed_b[63:32]);
    endfunction

endpackage

FILE: rtl/keyed_section_hash_table.sv
// Open-addressing hash table of TABLE_SLOTS entries keyed by a 64-bit section
// key, with linear probing and tombstones; one result item per input item.
// After reset the block clears every slot mark and stalls its input meanwhile.
// Items are handled one at a time: after the accepting cycle the key hash runs on
// one shared 32x32 multiplier (with an extra remainder step when TABLE_SLOTS is
// not a power of two), then every probed slot is read on the single read port of
// the key memory and checked, after which a decide step writes the slot and the
// result is posted. An item with bad bounds skips the hash and the probing.
module keyed_section_hash_table import ksht_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [63:0]         key,
    input  logic [63:0]         bounds_x,
    input  logic [63:0]         bounds_y,
    input  logic [63:0]         bounds_z,
    input  logic [31:0]         index_start,
    input  logic [31:0]         index_total,
    input  logic signed [31:0]  vertex_base,
    input  logic [31:0]         instance_start,
    input  logic [31:0]         material_bits,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [COUNT_W-1:0]  live_count,
    output logic [COUNT_W-1:0]  tombstone_count
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int SLOT_MW = KEY_W + 2;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  LAST_PROBE = CNT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W+4:0]  LOAD_LIMIT = (CNT_W + 5)'(TABLE_SLOTS * LOAD_DEN);

    state_t state_reg, state_next;

    logic              kind_reg;
    logic [63:0]       key_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic              bad_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic [CNT_W-1:0]  probe_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic              found_reg, tomb_seen_reg, empty_seen_reg;
    logic [SLOT_W-1:0] found_at_reg, tomb_at_reg, empty_at_reg;
    logic [CNT_W-1:0]  occ_reg, tomb_reg;
    status_t           res_status_reg;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [CNT_W+10:0] live_wide_reg, tomb_wide_reg;

    logic              accept;
    logic              bad_now;
    logic              hash_done;
    logic [SLOT_W-1:0] hash_home;
    logic [SLOT_MW-1:0] km_rd_data;
    logic              km_wr_en;
    logic [SLOT_W-1:0] km_wr_addr;
    logic [SLOT_MW-1:0] km_wr_data;
    logic              pl_wr_en;
    logic              km_rd_en;
    mark_t             rd_mark;
    logic              hit, is_empty, last_probe;
    logic [SLOT_W-1:0] dst;
    logic [CNT_W:0]    fill_sum;
    logic [CNT_W+4:0]  fill_scaled;
    logic              full;
    logic              out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign bad_now  = !kind && (bounds_bad(bounds_x) || bounds_bad(bounds_y)
                                || bounds_bad(bounds_z));
    assign out_free = !out_valid_reg || !out_stall;

    assign rd_mark    = mark_t'(km_rd_data[SLOT_MW-1:KEY_W]);
    assign is_empty   = (rd_mark == MARK_EMPTY);
    assign hit        = (rd_mark == MARK_LIVE) && (km_rd_data[KEY_W-1:0] == key_reg);
    assign last_probe = (probe_reg == LAST_PROBE);

    assign fill_sum    = {1'b0, occ_reg} + {1'b0, tomb_reg} + (CNT_W + 1)'(1);
    assign fill_scaled = ({4'd0, fill_sum} << 3) + ({4'd0, fill_sum} << 1);
    assign full        = (fill_scaled >= LOAD_LIMIT) || !empty_seen_reg;
    assign dst = found_reg ? found_at_reg : (tomb_seen_reg ? tomb_at_reg : empty_at_reg);

    ksht_hash #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_hash (
        .clk  (clk),
        .rst_n(rst_n),
        .start(accept && !bad_now),
        .key  (key),
        .done (hash_done),
        .home (hash_home)
    );

    ksht_ram #(
        .WIDTH(SLOT_MW),
        .DEPTH(TABLE_SLOTS)
    ) u_key_ram (
        .clk    (clk),
        .wr_en  (km_wr_en),
        .wr_addr(km_wr_addr),
        .wr_data(km_wr_data),
        .rd_en  (km_rd_en),
        .rd_addr(pos_reg),
        .rd_data(km_rd_data)
    );

    ksht_ram #(
        .WIDTH(PAYLOAD_W),
        .DEPTH(TABLE_SLOTS)
    ) u_payload_ram (
        .clk    (clk),
        .wr_en  (pl_wr_en),
        .wr_addr(dst),
        .wr_data(payload_reg),
        .rd_en  (1'b0),
        .rd_addr(dst),
        .rd_data()
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_reg == LAST_SLOT) state_next = S_IDLE;
            S_IDLE:   if (accept) state_next = bad_now ? S_DECIDE : S_HASH;
            S_HASH:   if (hash_done) state_next = S_RD;
            S_RD:     state_next = S_CHK;
            S_CHK:    state_next = (is_empty || hit || last_probe) ? S_DECIDE : S_RD;
            S_DECIDE: state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        km_wr_en   = 1'b0;
        km_wr_addr = dst;
        km_wr_data = {MARK_LIVE, key_reg};
        km_rd_en   = 1'b0;
        pl_wr_en   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                km_wr_en   = 1'b1;
                km_wr_addr = clr_reg;
                km_wr_data = {MARK_EMPTY, {KEY_W{1'b0}}};
            end
            S_RD:
            begin
                km_rd_en = 1'b1;
            end
            S_DECIDE:
            begin
                if (bad_reg)
                begin
                    km_wr_en = 1'b0;
                end
                else if (kind_reg)
                begin
                    km_wr_en   = found_reg;
                    km_wr_data = {MARK_TOMB, key_reg};
                end
                else
                begin
                    km_wr_en = found_reg || tomb_seen_reg || !full;
                    pl_wr_en = km_wr_en;
                end
            end
            default:
            begin
                km_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            occ_reg       <= '0;
            tomb_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (state_reg == S_DECIDE && !bad_reg)
            begin
                if (kind_reg)
                begin
                    if (found_reg)
                    begin
                        occ_reg  <= occ_reg - CNT_W'(1);
                        tomb_reg <= tomb_reg + CNT_W'(1);
                    end
                end
                else if (!found_reg && tomb_seen_reg)
                begin
                    occ_reg  <= occ_reg + CNT_W'(1);
                    tomb_reg <= tomb_reg - CNT_W'(1);
                end
                else if (!found_reg && !full)
                begin
                    occ_reg <= occ_reg + CNT_W'(1);
                end
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg       <= kind;
            key_reg        <= key;
            bad_reg        <= bad_now;
            payload_reg    <= {material_bits, instance_start, vertex_base, index_total,
                               index_start, bounds_z, bounds_y, bounds_x};
            found_reg      <= 1'b0;
            tomb_seen_reg  <= 1'b0;
            empty_seen_reg <= 1'b0;
            probe_reg      <= '0;
        end
        if (state_reg == S_HASH && hash_done)
        begin
            pos_reg <= hash_home;
        end
        if (state_reg == S_CHK)
        begin
            if (is_empty)
            begin
                empty_seen_reg <= 1'b1;
                empty_at_reg   <= pos_reg;
            end
            else if (hit)
            begin
                found_reg    <= 1'b1;
                found_at_reg <= pos_reg;
            end
            else
            begin
                if (rd_mark == MARK_TOMB && !tomb_seen_reg)
                begin
                    tomb_seen_reg <= 1'b1;
                    tomb_at_reg   <= pos_reg;
                end
                pos_reg   <= (pos_reg == LAST_SLOT) ? '0 : pos_reg + SLOT_W'(1);
                probe_reg <= probe_reg + CNT_W'(1);
            end
        end
        if (state_reg == S_DECIDE)
        begin
            if (bad_reg)
                res_status_reg <= ST_BAD_BOUNDS;
            else if (kind_reg)
                res_status_reg <= found_reg ? ST_OK : ST_MISSING;
            else if (found_reg || tomb_seen_reg || !full)
                res_status_reg <= ST_OK;
            else
                res_status_reg <= ST_FULL;
        end
        if (state_reg == S_OUT && out_free)
        begin
            status_reg    <= res_status_reg;
            live_wide_reg <= (CNT_W + 11)'(occ_reg);
            tomb_wide_reg <= (CNT_W + 11)'(tomb_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign live_count      = live_wide_reg[COUNT_W-1:0];
    assign tombstone_count = tomb_wide_reg[COUNT_W-1:0];

    a_hash_only_while_hashing: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == S_HASH)
        else $error("hash finished outside the hash phase");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, occ_reg} + {1'b0, tomb_reg}) <= (CNT_W + 1)'(TABLE_SLOTS))
        else $error("live plus tombstone count exceeds the table");

    a_write_only_when_deciding: assert property (@(posedge clk) disable iff (!rst_n)
        km_wr_en |-> (state_reg == S_CLEAR || state_reg == S_DECIDE))
        else $error("key memory written outside clear or decide");

    a_result_follows_decide: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE |=> state_reg == S_OUT)
        else $error("decision not followed by result posting");

endmodule

FILE: rtl/ksht_ram.sv
module ksht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/ksht_hash.sv
module ksht_hash import ksht_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [KEY_W-1:0]               key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] home
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(TABLE_SLOTS));
    localparam logic [32:0] SLOTS_33 = 33'(TABLE_SLOTS);

    hash_state_t h_reg, h_next;
    logic [63:0] v_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [63:0] val_reg;
    logic [1:0]  cnt_reg;
    logic [2:0]  digit_reg;
    logic        round_reg;
    logic [SLOT_W-1:0] rem_reg;

    logic [63:0] mul_c;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mixed;
    logic [SLOT_W-1:0] rem_step;
    logic [31:0] rem_t;
    logic [15:0] rem_q;
    logic [32:0] rem_d;
    logic [32:0] rem_fix;

    assign mul_c = round_reg ? HASH_MUL2 : HASH_MUL1;
    assign op_a  = (h_reg == H_REM) ? rem_t :
                   ((cnt_reg == 2'd2) ? v_reg[63:32] : v_reg[31:0]);
    assign op_b  = (h_reg == H_REM) ? RECIP :
                   ((cnt_reg == 2'd1) ? mul_c[63:32] : mul_c[31:0]);
    assign mixed = acc_reg ^ (acc_reg >> HASH_SH2);

    // Remainder by the slot count, sixteen hash bits per digit. The shared
    // multiplier estimates the quotient from a reciprocal; the estimate is at most
    // one low, so a single compare and subtract finishes the digit.
    assign rem_t   = (32'(rem_reg) << 16) | {16'd0, val_reg[63:48]};
    assign rem_q   = prod_reg[47:32];
    assign rem_d   = {1'b0, rem_t} - 33'(rem_q) * SLOTS_33;
    assign rem_fix = (rem_d >= SLOTS_33) ? rem_d - SLOTS_33 : rem_d;
    assign rem_step = rem_fix[SLOT_W-1:0];

    always_comb
    begin
        h_next = h_reg;
        unique case (h_reg)
            H_IDLE: if (start) h_next = H_MUL;
            H_MUL:  if (cnt_reg == 2'd3) h_next = H_MIX;
            H_MIX:
            begin
                if (!round_reg)
                    h_next = H_MUL;
                else if (IS_POW2)
                    h_next = H_IDLE;
                else
                    h_next = H_REM;
            end
            H_REM:  if (digit_reg == 3'd7) h_next = H_IDLE;
            default: h_next = H_IDLE;
        endcase
    end

    always_comb
    begin
        done = 1'b0;
        home = rem_step;
        unique case (h_reg)
            H_MIX:
            begin
                done = round_reg && IS_POW2;
                home = mixed[SLOT_W-1:0];
            end
            H_REM:   done = (digit_reg == 3'd7);
            default: done = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= H_IDLE;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        case (h_reg)
            H_IDLE:
            begin
                v_reg     <= key ^ (key >> HASH_SH0);
                round_reg <= 1'b0;
                cnt_reg   <= 2'd0;
            end
            H_MUL:
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                    acc_reg <= prod_reg;
                else if (cnt_reg != 2'd0)
                    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            end
            H_MIX:
            begin
                v_reg     <= acc_reg ^ (acc_reg >> HASH_SH1);
                round_reg <= 1'b1;
                cnt_reg   <= 2'd0;
                val_reg   <= mixed;
                rem_reg   <= '0;
                digit_reg <= 3'd0;
            end
            H_REM:
            begin
                if (digit_reg[0])
                begin
                    rem_reg <= rem_step;
                    val_reg <= val_reg << 16;
                end
                digit_reg <= digit_reg + 3'd1;
            end
            default:
            begin
                cnt_reg <= 2'd0;
            end
        endcase
    end

endmodule
